// ===== rtl/core/pidfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pidfd_pkg
// shared types, codes and saturating fixed-point helpers for the pid core
// ----------------------------------------------------------------------------
package pidfd_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam data_t GAIN_ONE = data_t'(1) <<< FRAC_W;

	localparam logic signed [PROD_W:0] RND_HALF    = (PROD_W+1)'(1) <<< (FRAC_W-1);
	localparam logic signed [PROD_W:0] RND_HALF_M1 = RND_HALF - (PROD_W+1)'(1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG_COEFF = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_POLE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_MODE    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_FREEZE_MODE = 3'd7;

	localparam logic       OP_EVAL  = 1'b0;
	localparam logic       OP_CLEAR = 1'b1;

	localparam logic       RUN_AUTO  = 1'b0;
	localparam logic       RUN_TRACK = 1'b1;

	localparam logic [1:0] FRZ_NONE = 2'd0;
	localparam logic [1:0] FRZ_UP   = 2'd1;
	localparam logic [1:0] FRZ_DOWN = 2'd2;

	localparam logic [1:0] SAT_NONE = 2'd0;
	localparam logic [1:0] SAT_HIGH = 2'd1;
	localparam logic [1:0] SAT_LOW  = 2'd2;

	typedef struct packed {
		data_t      prop_gain;
		data_t      integ_coeff;
		data_t      deriv_pole;
		data_t      deriv_gain;
		data_t      out_min;
		data_t      out_max;
		logic       run_mode;
		logic [1:0] freeze_mode;
	} cfg_t;

	function automatic data_t sat_add(data_t a, data_t b);
		logic [DATA_W:0] s;
		s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
		if (s[DATA_W] != s[DATA_W-1])
			return s[DATA_W] ? DATA_MIN : DATA_MAX;
		return data_t'(s[DATA_W-1:0]);
	endfunction

	function automatic data_t sat_sub(data_t a, data_t b);
		logic [DATA_W:0] s;
		s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		if (s[DATA_W] != s[DATA_W-1])
			return s[DATA_W] ? DATA_MIN : DATA_MAX;
		return data_t'(s[DATA_W-1:0]);
	endfunction

	// round to nearest, ties away from zero, then saturate
	function automatic data_t round_prod(prod_t p);
		logic signed [PROD_W:0]        r;
		logic        [PROD_W-FRAC_W:0] q;
		logic        [PROD_W-FRAC_W:DATA_W-1] hi;
		r  = $signed({p[PROD_W-1], p}) + (p[PROD_W-1] ? RND_HALF_M1 : RND_HALF);
		q  = r[PROD_W:FRAC_W];
		hi = q[PROD_W-FRAC_W:DATA_W-1];
		if ((&hi) || !(|hi))
			return data_t'(q[DATA_W-1:0]);
		return q[PROD_W-FRAC_W] ? DATA_MIN : DATA_MAX;
	endfunction

	function automatic data_t mul_round(data_t a, data_t b);
		prod_t p;
		p = a * b;
		return round_prod(p);
	endfunction

endpackage

// ===== rtl/core/pidfd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pidfd_cfg_regs
// configuration register file, written through a plain indexed write port
// ----------------------------------------------------------------------------
module pidfd_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [pidfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pidfd_pkg::DATA_W-1:0]     cfg_wdata,
	output pidfd_pkg::cfg_t                  cfg
);
	import pidfd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= GAIN_ONE;
			cfg_q.integ_coeff <= '0;
			cfg_q.deriv_pole  <= '0;
			cfg_q.deriv_gain  <= '0;
			cfg_q.out_min     <= DATA_MIN;
			cfg_q.out_max     <= DATA_MAX;
			cfg_q.run_mode    <= RUN_AUTO;
			cfg_q.freeze_mode <= FRZ_NONE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_PROP_GAIN:   cfg_q.prop_gain   <= data_t'(cfg_wdata);
				CFG_INTEG_COEFF: cfg_q.integ_coeff <= data_t'(cfg_wdata);
				CFG_DERIV_POLE:  cfg_q.deriv_pole  <= data_t'(cfg_wdata);
				CFG_DERIV_GAIN:  cfg_q.deriv_gain  <= data_t'(cfg_wdata);
				CFG_OUT_MIN:     cfg_q.out_min     <= data_t'(cfg_wdata);
				CFG_OUT_MAX:     cfg_q.out_max     <= data_t'(cfg_wdata);
				CFG_RUN_MODE:    cfg_q.run_mode    <= cfg_wdata[0];
				CFG_FREEZE_MODE: cfg_q.freeze_mode <= cfg_wdata[1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/pid_filtered_derivative_antiwindup_core.sv =====
// ----------------------------------------------------------------------------
// pid_filtered_derivative_antiwindup_core
// Q16.16 pid controller with filtered derivative, anti-windup and tracking
// ----------------------------------------------------------------------------
// Takes one beat per clock unless the output stalls and returns its result;
// a clear beat returns nothing. The rate is set by two unpipelined feedback
// loops: the derivative filter (one multiply, round and add) and the
// integral/output update (two adds, the limit compares and the selection).
// The products and the error difference sit in separate stages ahead of
// them. A stalled output fills the stage bubbles before input ready drops.
// ----------------------------------------------------------------------------
module pid_filtered_derivative_antiwindup_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [pidfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pidfd_pkg::DATA_W-1:0]     cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             opcode,
	input  pidfd_pkg::data_t                 measured,
	input  pidfd_pkg::data_t                 setpoint,
	input  pidfd_pkg::data_t                 track_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output pidfd_pkg::data_t                 drive,
	output logic [1:0]                       sat_status
);
	import pidfd_pkg::*;

	cfg_t cfg;

	pidfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// stage valids and enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	// payload
	logic  op_s1, op_s2, op_s3, op_s4, op_s5;
	data_t err_s1;
	data_t trk_s1, trk_s2, trk_s3, trk_s4, trk_s5;
	prod_t pe_prod_s2, ai_prod_s2, dd_prod_s3;
	data_t dif_s2;
	data_t pe_s3, pe_s4, pe_s5;
	data_t ai_s3, ai_s4, ai_s5;
	data_t dd_s4;
	data_t drive_s6;
	logic [1:0] sat_s6;

	// controller state
	data_t prev_err_q, deriv_q, integ_q, pdrv_q;

	// final stage logic
	logic       is_auto;
	data_t      raw_u, u_nxt, integ_nxt, bc_src, bc_val;
	logic [1:0] st_nxt;
	logic       hold;

	assign en6      = !v_s6 || out_ready;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_comb begin
		is_auto   = (cfg.run_mode == RUN_AUTO);
		raw_u     = is_auto ? sat_add(sat_add(pe_s5, integ_q), deriv_q) : trk_s5;
		hold      = ((cfg.freeze_mode == FRZ_UP) && (raw_u > pdrv_q)) ||
		            ((cfg.freeze_mode == FRZ_DOWN) && (raw_u < pdrv_q));
		bc_src    = is_auto ? pdrv_q : raw_u;
		bc_val    = sat_sub(sat_sub(bc_src, pe_s5), deriv_q);
		u_nxt     = raw_u;
		st_nxt    = SAT_NONE;
		integ_nxt = integ_q;
		if (raw_u > cfg.out_max) begin
			u_nxt  = cfg.out_max;
			st_nxt = SAT_HIGH;
		end else if (raw_u < cfg.out_min) begin
			u_nxt  = cfg.out_min;
			st_nxt = SAT_LOW;
		end else if (is_auto) begin
			if (hold) begin
				u_nxt     = pdrv_q;
				integ_nxt = bc_val;
			end else begin
				integ_nxt = sat_add(integ_q, ai_s5);
			end
		end else begin
			integ_nxt = bc_val;
		end
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
			v_s6       <= 1'b0;
			prev_err_q <= '0;
			deriv_q    <= '0;
			integ_q    <= '0;
			pdrv_q     <= '0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) begin
				v_s2 <= v_s1;
				if (v_s1)
					prev_err_q <= (op_s1 == OP_CLEAR) ? '0 : err_s1;
			end
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) begin
				v_s5 <= v_s4;
				if (v_s4)
					deriv_q <= (op_s4 == OP_CLEAR) ? '0 :
					           sat_add(mul_round(cfg.deriv_pole, deriv_q), dd_s4);
			end
			if (en6) begin
				v_s6 <= v_s5 && (op_s5 == OP_EVAL);
				if (v_s5) begin
					if (op_s5 == OP_CLEAR) begin
						integ_q <= '0;
						pdrv_q  <= '0;
					end else begin
						integ_q <= integ_nxt;
						pdrv_q  <= u_nxt;
					end
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1  <= opcode;
			err_s1 <= sat_sub(setpoint, measured);
			trk_s1 <= track_value;
		end
		if (en2) begin
			op_s2      <= op_s1;
			pe_prod_s2 <= cfg.prop_gain * err_s1;
			ai_prod_s2 <= cfg.integ_coeff * err_s1;
			dif_s2     <= sat_sub(err_s1, prev_err_q);
			trk_s2     <= trk_s1;
		end
		if (en3) begin
			op_s3      <= op_s2;
			pe_s3      <= round_prod(pe_prod_s2);
			ai_s3      <= round_prod(ai_prod_s2);
			dd_prod_s3 <= cfg.deriv_gain * dif_s2;
			trk_s3     <= trk_s2;
		end
		if (en4) begin
			op_s4  <= op_s3;
			pe_s4  <= pe_s3;
			ai_s4  <= ai_s3;
			dd_s4  <= round_prod(dd_prod_s3);
			trk_s4 <= trk_s3;
		end
		if (en5) begin
			op_s5  <= op_s4;
			pe_s5  <= pe_s4;
			ai_s5  <= ai_s4;
			trk_s5 <= trk_s4;
		end
		if (en6) begin
			drive_s6 <= u_nxt;
			sat_s6   <= st_nxt;
		end
	end

	assign out_valid  = v_s6;
	assign drive      = drive_s6;
	assign sat_status = sat_s6;

	a_ready_only_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !out_ready))
		else $error("input stalled with room in the pipeline");

	a_sat_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sat_status == SAT_NONE || sat_status == SAT_HIGH ||
		               sat_status == SAT_LOW))
		else $error("unused saturation code on output");

	a_sat_high_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sat_status == SAT_HIGH) |-> (drive == cfg.out_max))
		else $error("high saturation without upper limit");

	a_sat_low_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sat_status == SAT_LOW) |-> (drive == cfg.out_min))
		else $error("low saturation without lower limit");

endmodule

// ===== verif/pid_filtered_derivative_antiwindup_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_filtered_derivative_antiwindup_core_tb
// Self-checking bench for the Q16.16 pid core. A directed table covers the
// field extremes, the clear command, tracking, both freeze directions, output
// limiting and crossed limits. Random phases with fresh register settings
// follow. Each accepted beat runs through a bit-exact controller model in the
// bench, and every returned beat is compared field by field, in order.
// ----------------------------------------------------------------------------
module pid_filtered_derivative_antiwindup_core_tb;
	import pidfd_pkg::*;

	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int RAND_PHASES     = 12;
	localparam int BEATS_PER_PHASE = 100;
	localparam int SETTLE_CYCLES   = 20;
	localparam int DIR_ROWS        = 26;
	localparam int PRESETS         = 7;

	localparam logic [1:0] FRZ_UNUSED = 2'd3;

	localparam logic [2:0] PRE_RESET    = 3'd0;
	localparam logic [2:0] PRE_TIGHT    = 3'd1;
	localparam logic [2:0] PRE_TRACK    = 3'd2;
	localparam logic [2:0] PRE_FRZ_UP   = 3'd3;
	localparam logic [2:0] PRE_FRZ_DOWN = 3'd4;
	localparam logic [2:0] PRE_INVERT   = 3'd5;
	localparam logic [2:0] PRE_EXTREME  = 3'd6;

	typedef struct packed {
		data_t      drive;
		logic [1:0] sat;
	} ctl_result_t;

	typedef struct packed {
		logic [2:0] preset;
		logic       op;
		data_t      meas;
		data_t      sp;
		data_t      trk;
		logic       typed;
		data_t      x_drive;
		logic [1:0] x_sat;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic                 opcode;
	data_t                measured;
	data_t                setpoint;
	data_t                track_value;
	logic                 out_valid;
	logic                 out_ready;
	data_t                drive;
	logic [1:0]           sat_status;

	// typed expectation travelling with the beat
	logic                 beat_typed;
	data_t                beat_drive;
	logic [1:0]           beat_sat;

	logic                 src_idle;
	logic                 sink_idle;
	int                   mismatches = 0;
	int                   results_seen = 0;
	int                   quiet_cycles = 0;

	// controller copy: registers and state
	cfg_t  cfg_model = '{GAIN_ONE, '0, '0, '0, DATA_MIN, DATA_MAX, RUN_AUTO, FRZ_NONE};
	data_t err_last   = '0;
	data_t drive_last = '0;
	data_t integ_acc  = '0;
	data_t deriv_acc  = '0;

	ctl_result_t expected_results[$];

	cfg_t presets [0:PRESETS-1] = '{
		'{GAIN_ONE, 32'sh0, 32'sh0, 32'sh0, DATA_MIN, DATA_MAX, RUN_AUTO, FRZ_NONE},
		'{GAIN_ONE, 32'sh0000_4000, 32'sh0000_8000, 32'sh0001_0000,
			32'shFFFB_0000, 32'sh0005_0000, RUN_AUTO, FRZ_NONE},
		'{GAIN_ONE, 32'sh0000_4000, 32'sh0000_8000, 32'sh0001_0000,
			32'shFFFB_0000, 32'sh0005_0000, RUN_TRACK, FRZ_NONE},
		'{GAIN_ONE, 32'sh0000_8000, 32'sh0, 32'sh0, DATA_MIN, DATA_MAX, RUN_AUTO, FRZ_UP},
		'{GAIN_ONE, 32'sh0000_8000, 32'sh0, 32'sh0, DATA_MIN, DATA_MAX, RUN_AUTO, FRZ_DOWN},
		'{GAIN_ONE, 32'sh0, 32'sh0, 32'sh0, 32'sh0001_0000, 32'shFFFF_0000, RUN_AUTO, FRZ_NONE},
		'{DATA_MAX, DATA_MIN, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX, RUN_AUTO, FRZ_UNUSED}
	};

	dir_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{PRE_RESET, OP_EVAL, 32'sh0, 32'sh0, 32'sh0, 1'b1, 32'sh0, SAT_NONE},
		'{PRE_RESET, OP_EVAL, DATA_MIN, DATA_MAX, DATA_MIN, 1'b1, DATA_MAX, SAT_NONE},
		'{PRE_RESET, OP_EVAL, DATA_MAX, DATA_MIN, DATA_MAX, 1'b1, DATA_MIN, SAT_NONE},
		'{PRE_RESET, OP_EVAL, 32'sh1, 32'sh0, 32'sh0, 1'b1, 32'shFFFF_FFFF, SAT_NONE},
		'{PRE_RESET, OP_CLEAR, DATA_MAX, DATA_MAX, DATA_MAX, 1'b0, 32'sh0, SAT_NONE},
		'{PRE_RESET, OP_EVAL, 32'sh0001_0000, 32'sh0003_0000, 32'sh0, 1'b1,
			32'sh0002_0000, SAT_NONE},
		'{PRE_TIGHT, OP_EVAL, 32'sh0, 32'sh0004_0000, 32'sh0, 1'b0, 32'sh0, SAT_NONE},
		'{PRE_TIGHT, OP_EVAL, 32'sh0, 32'sh0008_0000, 32'sh0, 1'b0, 32'sh0, SAT_NONE},
		'{PRE_TIGHT, OP_EVAL, 32'sh0008_0000, 32'sh0, 32'sh0, 1'b0, 32'sh0, SAT_NONE},
		'{PRE_TIGHT, OP_CLEAR, 32'sh0, 32'sh0, 32'sh0, 1'b0, 32'sh0, SAT_NONE},
		'{PRE_TIGHT, OP_EVAL, 32'sh0000_8000, 32'sh0, 32'sh0, 1'b0, 32'sh0, SAT_NONE},
		'{PRE_TRACK, OP_EVAL, 32'sh0, 32'sh0001_0000, 32'sh0002_0000, 1'b0, 32'sh0, SAT_NONE},
		'{PRE_TRACK, OP_EVAL, 32'sh0, 32'sh0001_0000, 32'sh0007_0000, 1'b0, 32'sh0, SAT_NONE},
		'{PRE_TRACK, OP_EVAL, 32'sh0, 32'sh0001_0000, DATA_MIN, 1'b0, 32'sh0, SAT_NONE},
		'{PRE_FRZ_UP, OP_EVAL, 32'sh0, 32'sh0001_0000, 32'sh0, 1'b0, 32'sh0, SAT_NONE},
		'{PRE_FRZ_UP, OP_EVAL, 32'sh0, 32'sh0003_0000, 32'sh0, 1'b0, 32'sh0, SAT_NONE},
		'{PRE_FRZ_UP, OP_EVAL, 32'sh0002_0000, 32'sh0, 32'sh0, 1'b0, 32'sh0, SAT_NONE},
		'{PRE_FRZ_DOWN, OP_EVAL, 32'sh0, 32'sh0001_0000, 32'sh0, 1'b0, 32'sh0, SAT_NONE},
		'{PRE_FRZ_DOWN, OP_EVAL, 32'sh0003_0000, 32'sh0, 32'sh0, 1'b0, 32'sh0, SAT_NONE},
		'{PRE_FRZ_DOWN, OP_EVAL, 32'sh0, 32'sh0002_0000, 32'sh0, 1'b0, 32'sh0, SAT_NONE},
		'{PRE_INVERT, OP_CLEAR, 32'sh0, 32'sh0, 32'sh0, 1'b0, 32'sh0, SAT_NONE},
		'{PRE_INVERT, OP_EVAL, 32'sh0, 32'sh0002_0000, 32'sh0, 1'b1, 32'shFFFF_0000, SAT_HIGH},
		'{PRE_INVERT, OP_EVAL, 32'sh0005_0000, 32'sh0, 32'sh0, 1'b1, 32'sh0001_0000, SAT_LOW},
		'{PRE_INVERT, OP_EVAL, 32'sh0, 32'sh0, 32'sh0, 1'b1, 32'shFFFF_0000, SAT_HIGH},
		'{PRE_EXTREME, OP_EVAL, DATA_MIN, DATA_MAX, 32'sh0, 1'b0, 32'sh0, SAT_NONE},
		'{PRE_EXTREME, OP_EVAL, DATA_MAX, DATA_MIN, DATA_MAX, 1'b0, 32'sh0, SAT_NONE}
	};

	pid_filtered_derivative_antiwindup_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.measured    (measured),
		.setpoint    (setpoint),
		.track_value (track_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drive       (drive),
		.sat_status  (sat_status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// saturating fixed-point arithmetic
	function automatic data_t q_clamp(longint v);
		if (v > longint'(DATA_MAX))
			return DATA_MAX;
		if (v < longint'(DATA_MIN))
			return DATA_MIN;
		return data_t'(v);
	endfunction

	function automatic data_t q_add(data_t a, data_t b);
		return q_clamp(longint'(a) + longint'(b));
	endfunction

	function automatic data_t q_sub(data_t a, data_t b);
		return q_clamp(longint'(a) - longint'(b));
	endfunction

	// exact product, round half away from zero, then saturate
	function automatic data_t q_mul(data_t a, data_t b);
		longint prod;
		longint mag;
		prod = longint'(a) * longint'(b);
		mag  = (prod < 0) ? -prod : prod;
		mag  = (mag + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
		return q_clamp((prod < 0) ? -mag : mag);
	endfunction

	function automatic ctl_result_t pid_eval(data_t meas, data_t sp, data_t trk);
		data_t      err;
		data_t      p_term;
		data_t      u;
		data_t      lim_lo;
		data_t      lim_hi;
		logic [1:0] st;
		logic       is_auto;
		logic       hold;
		lim_lo    = cfg_model.out_min;
		lim_hi    = cfg_model.out_max;
		is_auto   = (cfg_model.run_mode == RUN_AUTO);
		err       = q_sub(sp, meas);
		deriv_acc = q_add(q_mul(cfg_model.deriv_pole, deriv_acc),
			q_mul(cfg_model.deriv_gain, q_sub(err, err_last)));
		p_term    = q_mul(cfg_model.prop_gain, err);
		u         = is_auto ? q_add(q_add(p_term, integ_acc), deriv_acc) : trk;
		st        = SAT_NONE;
		if (u > lim_hi) begin
			u  = lim_hi;
			st = SAT_HIGH;
		end else if (u < lim_lo) begin
			u  = lim_lo;
			st = SAT_LOW;
		end else if (is_auto) begin
			hold = (cfg_model.freeze_mode == FRZ_UP && u > drive_last) ||
				(cfg_model.freeze_mode == FRZ_DOWN && u < drive_last);
			if (hold) begin
				u         = drive_last;
				integ_acc = q_sub(q_sub(u, p_term), deriv_acc);
			end else begin
				integ_acc = q_add(integ_acc, q_mul(cfg_model.integ_coeff, err));
			end
		end else begin
			integ_acc = q_sub(q_sub(u, p_term), deriv_acc);
		end
		err_last   = err;
		drive_last = u;
		return '{drive: u, sat: st};
	endfunction

	task automatic report_mismatch(input string what, input data_t got, input data_t want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch on result %0d, %0s: got %h, want %h", results_seen, what, got, want);
	endtask

	// observe register writes and both channels
	always @(posedge clk) begin
		ctl_result_t want;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_PROP_GAIN:   cfg_model.prop_gain   = cfg_wdata;
					CFG_INTEG_COEFF: cfg_model.integ_coeff = cfg_wdata;
					CFG_DERIV_POLE:  cfg_model.deriv_pole  = cfg_wdata;
					CFG_DERIV_GAIN:  cfg_model.deriv_gain  = cfg_wdata;
					CFG_OUT_MIN:     cfg_model.out_min     = cfg_wdata;
					CFG_OUT_MAX:     cfg_model.out_max     = cfg_wdata;
					CFG_RUN_MODE:    cfg_model.run_mode    = cfg_wdata[0];
					CFG_FREEZE_MODE: cfg_model.freeze_mode = cfg_wdata[1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected", drive, '0);
				end else begin
					want = expected_results.pop_front();
					if (drive !== want.drive)
						report_mismatch("drive", drive, want.drive);
					if (sat_status !== want.sat)
						report_mismatch("sat_status", data_t'(sat_status), data_t'(want.sat));
				end
				results_seen++;
			end
			if (in_valid && in_ready) begin
				if (opcode == OP_CLEAR) begin
					err_last   = '0;
					drive_last = '0;
					integ_acc  = '0;
					deriv_acc  = '0;
				end else begin
					want = pid_eval(measured, setpoint, track_value);
					if (beat_typed)
						want = '{drive: beat_drive, sat: beat_sat};
					expected_results.push_back(want);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("pid_filtered_derivative_antiwindup_core regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side back-pressure
	initial begin
		out_ready = 1'b1;
		forever begin
			@(posedge clk);
			if (sink_idle && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	function automatic data_t pick_q();
		case ($urandom_range(0, 9))
			0:       return DATA_MIN;
			1:       return DATA_MAX;
			2, 3:    return data_t'($urandom);
			default: return data_t'($urandom_range(0, 20 << FRAC_W) - (10 << FRAC_W));
		endcase
	endfunction

	function automatic data_t pick_gain();
		case ($urandom_range(0, 7))
			0:       return DATA_MIN;
			1:       return DATA_MAX;
			2:       return data_t'($urandom);
			default: return data_t'($urandom_range(0, 4 << FRAC_W) - (2 << FRAC_W));
		endcase
	endfunction

	function automatic cfg_t pick_setting();
		cfg_t  c;
		data_t a;
		data_t b;
		c.prop_gain   = pick_gain();
		c.integ_coeff = pick_gain();
		c.deriv_pole  = pick_gain();
		c.deriv_gain  = pick_gain();
		a = pick_q();
		b = pick_q();
		case ($urandom_range(0, 4))
			0: begin
				c.out_min = DATA_MIN;
				c.out_max = DATA_MAX;
			end
			1: begin
				c.out_min = (a > b) ? a : b;
				c.out_max = (a > b) ? b : a;
			end
			default: begin
				c.out_min = (a > b) ? b : a;
				c.out_max = (a > b) ? a : b;
			end
		endcase
		c.run_mode    = ($urandom_range(0, 3) == 0) ? RUN_TRACK : RUN_AUTO;
		c.freeze_mode = 2'($urandom_range(0, 3));
		return c;
	endfunction

	task automatic send_beat(input logic op, input data_t m, input data_t s, input data_t t,
		input logic typed, input data_t x_drive, input logic [1:0] x_sat);
		if (src_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		measured    <= m;
		setpoint    <= s;
		track_value <= t;
		beat_typed  <= typed;
		beat_drive  <= x_drive;
		beat_sat    <= x_sat;
		do @(posedge clk); while (!in_ready);
	endtask

	// wait for every result, then let a trailing clear beat leave the pipe
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_setting(input cfg_t c);
		logic [DATA_W-1:0] junk;
		for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
			junk = $urandom;
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			case (CFG_IDX_W'(i))
				CFG_PROP_GAIN:   cfg_wdata <= c.prop_gain;
				CFG_INTEG_COEFF: cfg_wdata <= c.integ_coeff;
				CFG_DERIV_POLE:  cfg_wdata <= c.deriv_pole;
				CFG_DERIV_GAIN:  cfg_wdata <= c.deriv_gain;
				CFG_OUT_MIN:     cfg_wdata <= c.out_min;
				CFG_OUT_MAX:     cfg_wdata <= c.out_max;
				CFG_RUN_MODE:    cfg_wdata <= {junk[DATA_W-1:1], c.run_mode};
				default:         cfg_wdata <= {junk[DATA_W-1:2], c.freeze_mode};
			endcase
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int cur_preset;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_index   = '0;
		cfg_wdata   = '0;
		in_valid    = 1'b0;
		opcode      = OP_EVAL;
		measured    = '0;
		setpoint    = '0;
		track_value = '0;
		beat_typed  = 1'b0;
		beat_drive  = '0;
		beat_sat    = SAT_NONE;
		src_idle    = 1'b0;
		sink_idle   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_preset = PRE_RESET;
		foreach (dir_rows[r]) begin
			if (dir_rows[r].preset != cur_preset) begin
				drain();
				write_setting(presets[dir_rows[r].preset]);
				cur_preset = dir_rows[r].preset;
			end
			send_beat(dir_rows[r].op, dir_rows[r].meas, dir_rows[r].sp, dir_rows[r].trk,
				dir_rows[r].typed, dir_rows[r].x_drive, dir_rows[r].x_sat);
		end

		// last two phases run without idling
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			write_setting(pick_setting());
			src_idle  = (ph < RAND_PHASES - 2) && (ph % 3 != 2);
			sink_idle <= (ph < RAND_PHASES - 2) && (ph % 3 != 1);
			repeat (BEATS_PER_PHASE)
				send_beat(($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_EVAL,
					pick_q(), pick_q(), pick_q(), 1'b0, '0, SAT_NONE);
		end
		drain();

		if (mismatches == 0)
			$display("pid_filtered_derivative_antiwindup_core regression: pass");
		else
			$display("pid_filtered_derivative_antiwindup_core regression: fail");
		$finish;
	end

endmodule
